### hw/rtl/rdsrt_pkg.sv
// Shared types and constants for the RDS radiotext assembler.
package rdsrt_pkg;

  // Text store geometry.
  localparam int TEXT_CHARS = 64;
  localparam int IDX_W      = 6;
  localparam int LEN_W      = 7;

  // Character codes and group type codes.
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] STAR_CODE  = 8'h2A;
  localparam logic [4:0] GROUP_2A   = 5'd4;
  localparam logic [4:0] GROUP_2B   = 5'd5;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ
  } state_t;

  // Request from the sequencer to the text store.
  typedef struct packed {
    logic             clear;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Readout status from the sequencer to the output stage.
  typedef struct packed {
    logic             pend;
    logic [IDX_W-1:0] idx;
    logic             last;
  } rd_stat_t;

endpackage

### hw/rtl/rdsrt_store.sv
// Text store: 64 x 8 character memory with per-entry written flags.
module rdsrt_store (
  input  logic                clk,
  input  logic                rst,
  input  rdsrt_pkg::mem_req_t req,
  output logic [7:0]          rd_data,
  output logic                rd_vld
);
  import rdsrt_pkg::*;

  logic [7:0]            mem [TEXT_CHARS];
  logic [TEXT_CHARS-1:0] written;

  // Character memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

  // Written flags; a clear drops them all at once so entries read as space.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  // Flag of the entry being read travels with its data.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_vld <= written[req.raddr];
    end
  end

endmodule

### hw/rtl/rdsrt_ctrl.sv
// Sequencer: group decode, character writes, text length and readout issue.
module rdsrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         group_b_word,
  input  logic                group_b_ok,
  input  logic [15:0]         group_c_word,
  input  logic                group_c_ok,
  input  logic [15:0]         group_d_word,
  input  logic                group_d_ok,
  input  logic                load,
  output rdsrt_pkg::mem_req_t req,
  output rdsrt_pkg::rd_stat_t rd
);
  import rdsrt_pkg::*;

  state_t           state, state_next;
  logic             ab_marker;
  logic [LEN_W-1:0] text_len;
  logic             is_2a;
  logic [3:0]       seg;
  logic [15:0]      c_word, d_word;
  logic             c_ok, d_ok;
  logic [1:0]       wr_cnt;
  logic [LEN_W-1:0] issue_idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  logic             accept, group_take, do_clear;
  logic [4:0]       code;
  logic             wr_last;
  logic [IDX_W-1:0] wr_pos;
  logic [15:0]      wr_word;
  logic             wr_ok;
  logic [7:0]       wr_char;
  logic             issue, read_done;

  // Input decode.
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign code       = group_b_word[15:11];
  assign group_take = accept && group_b_ok && (code == GROUP_2A || code == GROUP_2B);
  assign do_clear   = group_take && (group_b_word[4] != ab_marker);

  // Character selection for the current write step.
  assign wr_last = is_2a ? (wr_cnt == 2'd3) : (wr_cnt == 2'd1);
  assign wr_pos  = (is_2a ? {seg, 2'b00} : {1'b0, seg, 1'b0}) + IDX_W'(wr_cnt);
  assign wr_word = (is_2a && !wr_cnt[1]) ? c_word : d_word;
  assign wr_ok   = (is_2a && !wr_cnt[1]) ? c_ok : d_ok;
  always_comb begin
    if (!wr_ok) begin
      wr_char = STAR_CODE;
    end else if (!wr_cnt[0]) begin
      wr_char = wr_word[15:8];
    end else begin
      wr_char = wr_word[7:0];
    end
  end

  // Readout issue: one store read per cycle while the pending slot frees up.
  assign issue     = (state == ST_READ) && (issue_idx < text_len) && (!rd_pend || load);
  assign read_done = (issue_idx == text_len) && !rd_pend;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (group_take) state_next = ST_WRITE;
      ST_WRITE: if (wr_last) state_next = ST_READ;
      ST_READ:  if (read_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Store requests.
  always_comb begin
    req       = '0;
    req.clear = do_clear;
    req.waddr = wr_pos;
    req.wdata = wr_char;
    req.raddr = issue_idx[IDX_W-1:0];
    case (state)
      ST_WRITE: req.we = 1'b1;
      ST_READ:  req.re = issue;
      default:  req.we = 1'b0;
    endcase
  end

  assign rd.pend = rd_pend;
  assign rd.idx  = rd_idx;
  assign rd.last = ({1'b0, rd_idx} + LEN_W'(1)) == text_len;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ab_marker <= 1'b1;
      text_len  <= '0;
      wr_cnt    <= '0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (group_take) begin
        ab_marker <= group_b_word[4];
        wr_cnt    <= '0;
        issue_idx <= '0;
        if (do_clear) begin
          text_len <= '0;
        end
      end
      // Length grows to cover each written character.
      if (state == ST_WRITE) begin
        wr_cnt <= wr_cnt + 2'd1;
        if ({1'b0, wr_pos} + LEN_W'(1) > text_len) begin
          text_len <= {1'b0, wr_pos} + LEN_W'(1);
        end
      end
      if (issue) begin
        issue_idx <= issue_idx + LEN_W'(1);
        rd_pend   <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end
    end
  end

  // Group payload and readout index.
  always_ff @(posedge clk) begin
    if (group_take) begin
      is_2a  <= (code == GROUP_2A);
      seg    <= group_b_word[3:0];
      c_word <= group_c_word;
      c_ok   <= group_c_ok;
      d_word <= group_d_word;
      d_ok   <= group_d_ok;
    end
    if (issue) begin
      rd_idx <= issue_idx[IDX_W-1:0];
    end
  end

  // A pending read only exists during readout.
  a_pend_in_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_READ)
    else $error("read pending outside readout");

  // The text never outgrows the store.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    text_len <= LEN_W'(TEXT_CHARS))
    else $error("text length beyond store size");

  // Issue never runs past the text.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_idx <= text_len || state != ST_READ)
    else $error("readout index past text length");

  // A usable group always starts the write phase.
  a_take_write: assert property (@(posedge clk) disable iff (rst)
    group_take |=> state == ST_WRITE)
    else $error("accepted group did not start writing");

  // The length holds steady while the text is read out.
  a_len_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && $past(state) == ST_READ) |-> $stable(text_len))
    else $error("text length changed during readout");

endmodule

### hw/rtl/rds_radiotext_assembler.sv
// Top level of the RDS radiotext assembler: sequencer, text store, output register.
//
// Each accepted group (2A or 2B with a good block B) first writes its characters
// (four for 2A, two for 2B) into the text store. It then streams the whole text
// out at up to one character per cycle, while the output side does not stall,
// through the single read port of the text store. The sequencer then waits for
// the last read to drain and returns to idle. in_stall stays high from the taken
// group until that return, and stalls on the output side lengthen it. The next
// group can be taken once in_stall is low. Other groups are taken while idle and
// give no transfer. A change of the A/B flag clears the text in the same cycle
// the group is taken. The last character of each text carries is_last.
module rds_radiotext_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] group_b_word,
  input  logic        group_b_ok,
  input  logic [15:0] group_c_word,
  input  logic        group_c_ok,
  input  logic [15:0] group_d_word,
  input  logic        group_d_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  char_index,
  output logic [7:0]  char_code,
  output logic        is_last
);
  import rdsrt_pkg::*;

  mem_req_t   req;
  rd_stat_t   rd;
  logic [7:0] rd_data;
  logic       rd_vld;
  logic       load;

  rdsrt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .group_b_word (group_b_word),
    .group_b_ok   (group_b_ok),
    .group_c_word (group_c_word),
    .group_c_ok   (group_c_ok),
    .group_d_word (group_d_word),
    .group_d_ok   (group_d_ok),
    .load         (load),
    .req          (req),
    .rd           (rd)
  );

  rdsrt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  // The pending character moves out when the output register is free or taken.
  assign load = rd.pend && (!out_valid || !out_stall);

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; unwritten positions read as space.
  always_ff @(posedge clk) begin
    if (load) begin
      char_index <= rd.idx;
      char_code  <= rd_vld ? rd_data : SPACE_CODE;
      is_last    <= rd.last;
    end
  end

endmodule

### bench/testbench.sv
// Self-checking testbench for the RDS radiotext assembler (groups 2A and 2B).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdsrt_pkg::*;

  localparam int NO_CHECK      = -1;
  localparam int RANDOM_GROUPS = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 80;

  // One group offered to the block, with an optional hand-typed readout summary.
  typedef struct packed {
    logic [15:0] b_word;
    logic        b_ok;
    logic [15:0] c_word;
    logic        c_ok;
    logic [15:0] d_word;
    logic        d_ok;
    int          want_len;
    logic [7:0]  want_tail;
  } group_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]       code;
    logic             last;
  } text_char_t;

  typedef struct packed {
    int         len;
    logic [7:0] tail;
  } text_summary_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] group_b_word = '0;
  logic        group_b_ok = 1'b0;
  logic [15:0] group_c_word = '0;
  logic        group_c_ok = 1'b0;
  logic [15:0] group_d_word = '0;
  logic        group_d_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  char_index;
  logic [7:0]  char_code;
  logic        is_last;

  // Predicted radiotext state.
  logic [7:0] shadow_text [TEXT_CHARS];
  int         shadow_len;
  logic       shadow_ab;

  text_char_t    expected_chars [$];
  text_summary_t expected_texts [$];

  int fail_count;
  int groups_sent;
  int texts_expected;
  int chars_checked;
  int clears_seen;
  int text_pos;
  bit hold_off_req;

  rds_radiotext_assembler dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .group_b_word (group_b_word),
    .group_b_ok   (group_b_ok),
    .group_c_word (group_c_word),
    .group_c_ok   (group_c_ok),
    .group_d_word (group_d_word),
    .group_d_ok   (group_d_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_index   (char_index),
    .char_code    (char_code),
    .is_last      (is_last)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Timeout at %0t with %0d characters outstanding", $time, expected_chars.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic group_row_t make_row(logic [4:0] kind, logic ab, logic [3:0] seg,
                                          logic [5:0] fill, logic b_ok,
                                          logic [15:0] c_word, logic c_ok,
                                          logic [15:0] d_word, logic d_ok,
                                          int want_len, logic [7:0] want_tail);
    group_row_t row;
    row.b_word    = {kind, fill, ab, seg};
    row.b_ok      = b_ok;
    row.c_word    = c_word;
    row.c_ok      = c_ok;
    row.d_word    = d_word;
    row.d_ok      = d_ok;
    row.want_len  = want_len;
    row.want_tail = want_tail;
    return row;
  endfunction

  function automatic void clear_shadow();
    for (int k = 0; k < TEXT_CHARS; k++) shadow_text[k] = SPACE_CODE;
    shadow_len = 0;
  endfunction

  // A bad block puts two stars in place of its characters.
  function automatic void write_pair(int pos, logic [15:0] word, logic ok);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = ok ? word[15:8] : STAR_CODE;
    lo = ok ? word[7:0] : STAR_CODE;
    if (pos < TEXT_CHARS) shadow_text[pos] = hi;
    if (pos + 1 < TEXT_CHARS) shadow_text[pos + 1] = lo;
    if (pos + 2 > shadow_len) shadow_len = (pos + 2 > TEXT_CHARS) ? TEXT_CHARS : pos + 2;
  endfunction

  // Applies one accepted group and queues the text readout it should cause.
  function automatic int apply_group(group_row_t row);
    logic [4:0] kind;
    int         seg;
    text_char_t ch;
    kind = row.b_word[15:11];
    if (!row.b_ok || (kind != GROUP_2A && kind != GROUP_2B)) return 0;
    seg = int'(row.b_word[3:0]);
    if (row.b_word[4] != shadow_ab) begin
      clear_shadow();
      clears_seen++;
    end
    shadow_ab = row.b_word[4];
    if (kind == GROUP_2A) begin
      write_pair(seg * 4, row.c_word, row.c_ok);
      write_pair(seg * 4 + 2, row.d_word, row.d_ok);
    end else begin
      write_pair(seg * 2, row.d_word, row.d_ok);
    end
    for (int k = 0; k < shadow_len; k++) begin
      ch.idx  = k[IDX_W-1:0];
      ch.code = shadow_text[k];
      ch.last = (k + 1 == shadow_len);
      expected_chars.push_back(ch);
    end
    return shadow_len;
  endfunction

  function automatic void report(string what, int want, int got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endfunction

  // Sender idle: mostly none or short, now and then long.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Offers one group and holds it until the transfer happens.
  task automatic send_group(group_row_t row);
    int produced;
    text_summary_t summary;
    group_b_word <= row.b_word;
    group_b_ok   <= row.b_ok;
    group_c_word <= row.c_word;
    group_c_ok   <= row.c_ok;
    group_d_word <= row.d_word;
    group_d_ok   <= row.d_ok;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    groups_sent++;
    produced = apply_group(row);
    if (produced > 0) begin
      summary.len  = row.want_len;
      summary.tail = row.want_tail;
      expected_texts.push_back(summary);
      texts_expected++;
    end
  endtask

  task automatic idle_sender();
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: reset, directed table, then random groups.
  initial begin
    group_row_t directed_rows [$];
    group_row_t row;
    logic       rand_ab;

    clear_shadow();
    shadow_ab = 1'b1;
    directed_rows = '{
      // Block B bad and other group codes.
      make_row(GROUP_2A, 1'b1, 4'd0, 6'h00, 1'b0, 16'h4142, 1'b1, 16'h4344, 1'b1, 0, 8'h00),
      make_row(GROUP_2A - 5'd1, 1'b1, 4'd2, 6'h00, 1'b1, 16'h4142, 1'b1, 16'h4344, 1'b1,
               0, 8'h00),
      make_row(GROUP_2B + 5'd1, 1'b1, 4'd2, 6'h00, 1'b1, 16'h4142, 1'b1, 16'h4344, 1'b1,
               0, 8'h00),
      // Same flag as after reset, so no clear; text grows with gaps of spaces.
      make_row(GROUP_2B, 1'b1, 4'd0, 6'h00, 1'b1, 16'h0000, 1'b1, 16'h4142, 1'b1, 2, 8'h42),
      make_row(GROUP_2B, 1'b1, 4'd15, 6'h00, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1,
               32, 8'hFF),
      make_row(GROUP_2A, 1'b1, 4'd15, 6'h00, 1'b1, 16'h0000, 1'b1, 16'hFF00, 1'b1,
               64, 8'h00),
      make_row(GROUP_2A, 1'b1, 4'd0, 6'h00, 1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 64, 8'h00),
      // Flag change clears the text before the write.
      make_row(GROUP_2A, 1'b0, 4'd0, 6'h00, 1'b1, 16'h5A5A, 1'b1, 16'h1234, 1'b0,
               4, STAR_CODE),
      make_row(GROUP_2B, 1'b0, 4'd3, 6'h00, 1'b1, 16'h0000, 1'b1, 16'h0000, 1'b0,
               8, STAR_CODE),
      make_row(GROUP_2A, 1'b0, 4'd7, 6'h2A, 1'b1, 16'hA55A, 1'b1, 16'h1234, 1'b1, 32, 8'h34),
      make_row(GROUP_2B, 1'b1, 4'd1, 6'h00, 1'b1, 16'h0000, 1'b0, 16'h8001, 1'b1, 4, 8'h01),
      make_row('1, 1'b1, 4'd15, '1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 0, 8'h00),
      make_row('0, 1'b0, 4'd0, '0, 1'b1, 16'h0000, 1'b1, 16'h0000, 1'b1, 0, 8'h00),
      // A flag change in a rejected group must not clear.
      make_row(GROUP_2A, 1'b0, 4'd5, 6'h00, 1'b0, 16'h1111, 1'b1, 16'h2222, 1'b1, 0, 8'h00),
      make_row(GROUP_2B, 1'b1, 4'd0, 6'h00, 1'b1, 16'h0000, 1'b0, 16'h7F80, 1'b1, 4, 8'h01),
      make_row(GROUP_2A, 1'b1, 4'd15, 6'h00, 1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0,
               64, STAR_CODE),
      make_row(GROUP_2A, 1'b0, 4'd15, 6'h3F, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1,
               64, 8'hFF),
      make_row(GROUP_2B, 1'b0, 4'd15, 6'h15, 1'b1, 16'h1111, 1'b1, 16'h0102, 1'b0,
               NO_CHECK, 8'h00),
      make_row(GROUP_2A, 1'b0, 4'd3, 6'h00, 1'b1, 16'h2020, 1'b1, 16'h0000, 1'b1,
               NO_CHECK, 8'h00),
      make_row(GROUP_2B, 1'b1, 4'd8, 6'h00, 1'b1, 16'h0000, 1'b1, 16'h6162, 1'b1, 18, 8'h62)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_group(directed_rows[i]);
      idle_sender();
    end

    // Random groups; the receiver holds off once early on to back up the block.
    hold_off_req = 1'b1;
    rand_ab      = shadow_ab;
    for (int g = 0; g < RANDOM_GROUPS; g++) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 5) == 0) rand_ab = ~rand_ab;
        row = make_row(($urandom_range(0, 1) == 1) ? GROUP_2A : GROUP_2B, rand_ab,
                       4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)), 1'b1,
                       16'($urandom_range(0, 65535)), ($urandom_range(0, 99) < 85),
                       16'($urandom_range(0, 65535)), ($urandom_range(0, 99) < 85),
                       NO_CHECK, 8'h00);
      end else begin
        row = make_row(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                       4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                       NO_CHECK, 8'h00);
      end
      send_group(row);
      idle_sender();
    end
    in_valid <= 1'b0;

    // Drain: every predicted character must come out, then nothing else.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d groups: %0d readouts, %0d characters checked, %0d text clears.",
             groups_sent, texts_expected, chars_checked, clears_seen);
    $display("Covered rejected groups, bad C/D blocks, flag clears and texts up to %0d chars.",
             TEXT_CHARS);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int n;
    int run;
    int r;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 20);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 4);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Compare each character transfer with the oldest predicted character.
  always @(posedge clk) begin : check_output
    text_char_t    want;
    text_summary_t summary;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character transfer, expected none, got index %0d code %0h last %0b",
                 $time, char_index, char_code, is_last);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (char_index != want.idx) report("char_index", want.idx, char_index);
        if (char_code != want.code) report("char_code", want.code, char_code);
        if (is_last != want.last) report("is_last", want.last, is_last);
      end
      text_pos++;
      // Hand-typed length and final character, where the table gives them.
      if (is_last) begin
        if (expected_texts.size() != 0) begin
          summary = expected_texts.pop_front();
          if (summary.len != NO_CHECK) begin
            if (text_pos != summary.len) report("text length", summary.len, text_pos);
            if (char_code != summary.tail) report("final character", summary.tail, char_code);
          end
        end
        text_pos = 0;
      end
    end
  end

endmodule
